/* sv/categorical_label_normalizer_defines.svh */
// Assertion helpers shared by the RTL.
`ifndef CATEGORICAL_LABEL_NORMALIZER_DEFINES_SVH
`define CATEGORICAL_LABEL_NORMALIZER_DEFINES_SVH

// Expression must hold at every clock edge out of reset.
`define CLN_ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define CLN_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/cln_pkg.sv */
package cln_pkg;

    localparam int LABEL_W = 32;
    localparam int CLASS_W = 6;
    localparam int CNT_W   = 7;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_INS_RD,
        ST_INS_VAL,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_RK_RD,
        ST_RK_VAL,
        ST_RK_SRD,
        ST_RK_CMP,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_WAIT
    } state_t;

endpackage

/* sv/cln_ram.sv */
// Simple dual-port RAM, registered read.
module cln_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/categorical_label_normalizer.sv */
// Load accepts one item per cycle. After the last item, each sample is
// inserted by a walk over the sorted label RAM (a read and a compare state
// per entry visited, plus a read and a write state per entry shifted), then
// ranked by a second walk; all of this comes before the first result.
// Results leave one at a time; the next is read only after the sink takes one.
// Reset clears fill level, overflow flag and the sequencer; RAMs are not cleared.
`include "categorical_label_normalizer_defines.svh"

module categorical_label_normalizer #(
    parameter int MAX_SAMPLES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_sample_value,
    input  logic        s_is_missing,
    input  logic        s_last_sample,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_sample_class,
    output logic [31:0] m_class_label,
    output logic [6:0]  m_class_count,
    output logic        m_class_valid,
    output logic [6:0]  m_class_total,
    output logic        m_overflow,
    output logic        m_last_result
);

    localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int LW = cln_pkg::LABEL_W;
    localparam int CW = cln_pkg::CNT_W;
    localparam int RW = cln_pkg::CLASS_W;

    // Sequencer state and counters
    cln_pkg::state_t state_reg, state_next;
    logic [CW-1:0] fill_reg, fill_next;     // samples stored in this set
    logic          drop_reg, drop_next;     // an item was dropped
    logic [CW-1:0] idx_reg, idx_next;       // current sample / result
    logic [CW-1:0] pos_reg, pos_next;       // walk position in label RAM
    logic [CW-1:0] k_reg, k_next;           // shift position
    logic [CW-1:0] total_reg, total_next;   // distinct labels so far
    logic [LW-1:0] val_reg, val_next;       // value being inserted / ranked

    // Output register
    logic [RW-1:0] o_class_reg, o_class_next;
    logic [LW-1:0] o_label_reg, o_label_next;
    logic [CW-1:0] o_count_reg, o_count_next;
    logic          o_valid_reg, o_valid_next;
    logic          o_last_reg, o_last_next;

    // RAM ports
    logic          smp_we;
    logic [AW-1:0] smp_waddr, smp_raddr;
    logic [LW-1:0] smp_wdata, smp_rdata;
    logic          lab_we, cnt_we, rnk_we;
    logic [AW-1:0] lc_waddr, lc_raddr, rnk_waddr, rnk_raddr;
    logic [LW-1:0] lab_wdata, lab_rdata;
    logic [CW-1:0] cnt_wdata, cnt_rdata;
    logic [RW-1:0] rnk_wdata, rnk_rdata;

    logic          in_acc;
    logic          full;
    logic          idx_end;
    logic [CW-1:0] k_dec;

    cln_ram #(.WIDTH(LW), .DEPTH(MAX_SAMPLES), .AW(AW)) u_sample_ram (
        .aclk(aclk), .we(smp_we), .waddr(smp_waddr), .wdata(smp_wdata),
        .raddr(smp_raddr), .rdata(smp_rdata)
    );

    cln_ram #(.WIDTH(LW), .DEPTH(MAX_SAMPLES), .AW(AW)) u_label_ram (
        .aclk(aclk), .we(lab_we), .waddr(lc_waddr), .wdata(lab_wdata),
        .raddr(lc_raddr), .rdata(lab_rdata)
    );

    cln_ram #(.WIDTH(CW), .DEPTH(MAX_SAMPLES), .AW(AW)) u_count_ram (
        .aclk(aclk), .we(cnt_we), .waddr(lc_waddr), .wdata(cnt_wdata),
        .raddr(lc_raddr), .rdata(cnt_rdata)
    );

    cln_ram #(.WIDTH(RW), .DEPTH(MAX_SAMPLES), .AW(AW)) u_rank_ram (
        .aclk(aclk), .we(rnk_we), .waddr(rnk_waddr), .wdata(rnk_wdata),
        .raddr(rnk_raddr), .rdata(rnk_rdata)
    );

    assign s_ready = (state_reg == cln_pkg::ST_LOAD);
    assign m_valid = (state_reg == cln_pkg::ST_OUT_WAIT);
    assign in_acc  = s_valid && s_ready;
    assign full    = (fill_reg == CW'(MAX_SAMPLES));
    assign idx_end = (idx_reg + CW'(1) == fill_reg);
    assign k_dec   = k_reg - CW'(1);

    assign m_sample_class = o_class_reg;
    assign m_class_label  = o_label_reg;
    assign m_class_count  = o_count_reg;
    assign m_class_valid  = o_valid_reg;
    assign m_class_total  = total_reg;
    assign m_overflow     = drop_reg;
    assign m_last_result  = o_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cln_pkg::ST_LOAD;
            fill_reg  <= '0;
            drop_reg  <= 1'b0;
            idx_reg   <= '0;
            pos_reg   <= '0;
            k_reg     <= '0;
            total_reg <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            drop_reg  <= drop_next;
            idx_reg   <= idx_next;
            pos_reg   <= pos_next;
            k_reg     <= k_next;
            total_reg <= total_next;
        end
        val_reg     <= val_next;
        o_class_reg <= o_class_next;
        o_label_reg <= o_label_next;
        o_count_reg <= o_count_next;
        o_valid_reg <= o_valid_next;
        o_last_reg  <= o_last_next;
    end

    always_comb begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        drop_next    = drop_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        k_next       = k_reg;
        total_next   = total_reg;
        val_next     = val_reg;
        o_class_next = o_class_reg;
        o_label_next = o_label_reg;
        o_count_next = o_count_reg;
        o_valid_next = o_valid_reg;
        o_last_next  = o_last_reg;

        smp_we    = 1'b0;
        smp_waddr = fill_reg[AW-1:0];
        smp_wdata = s_is_missing ? '1 : s_sample_value;
        smp_raddr = idx_reg[AW-1:0];
        lab_we    = 1'b0;
        cnt_we    = 1'b0;
        lc_waddr  = pos_reg[AW-1:0];
        lab_wdata = val_reg;
        cnt_wdata = CW'(1);
        lc_raddr  = pos_reg[AW-1:0];
        rnk_we    = 1'b0;
        rnk_waddr = idx_reg[AW-1:0];
        rnk_wdata = pos_reg[RW-1:0];
        rnk_raddr = idx_reg[AW-1:0];

        case (state_reg)
            cln_pkg::ST_LOAD: begin
                if (in_acc) begin
                    if (full) begin
                        drop_next = 1'b1;
                    end else begin
                        smp_we    = 1'b1;
                        fill_next = fill_reg + CW'(1);
                    end
                    if (s_last_sample) begin
                        idx_next   = '0;
                        total_next = '0;
                        state_next = cln_pkg::ST_INS_RD;
                    end
                end
            end
            // Insertion sort of distinct values, one sample at a time
            cln_pkg::ST_INS_RD: begin
                state_next = cln_pkg::ST_INS_VAL;
            end
            cln_pkg::ST_INS_VAL: begin
                val_next   = smp_rdata;
                pos_next   = '0;
                state_next = cln_pkg::ST_SRCH_RD;
            end
            cln_pkg::ST_SRCH_RD: begin
                if (pos_reg == total_reg) begin
                    k_next     = total_reg;
                    state_next = cln_pkg::ST_SHIFT_RD;
                end else begin
                    state_next = cln_pkg::ST_SRCH_CMP;
                end
            end
            cln_pkg::ST_SRCH_CMP: begin
                if ($signed(lab_rdata) < $signed(val_reg)) begin
                    pos_next   = pos_reg + CW'(1);
                    state_next = cln_pkg::ST_SRCH_RD;
                end else if (lab_rdata == val_reg) begin
                    cnt_we    = 1'b1;
                    cnt_wdata = cnt_rdata + CW'(1);
                    if (idx_end) begin
                        idx_next   = '0;
                        state_next = cln_pkg::ST_RK_RD;
                    end else begin
                        idx_next   = idx_reg + CW'(1);
                        state_next = cln_pkg::ST_INS_RD;
                    end
                end else begin
                    k_next     = total_reg;
                    state_next = cln_pkg::ST_SHIFT_RD;
                end
            end
            // Open a slot at pos by moving entries up one place, top first
            cln_pkg::ST_SHIFT_RD: begin
                lc_raddr = k_dec[AW-1:0];
                if (k_reg == pos_reg) begin
                    lab_we     = 1'b1;
                    cnt_we     = 1'b1;
                    total_next = total_reg + CW'(1);
                    if (idx_end) begin
                        idx_next   = '0;
                        state_next = cln_pkg::ST_RK_RD;
                    end else begin
                        idx_next   = idx_reg + CW'(1);
                        state_next = cln_pkg::ST_INS_RD;
                    end
                end else begin
                    state_next = cln_pkg::ST_SHIFT_WR;
                end
            end
            cln_pkg::ST_SHIFT_WR: begin
                lab_we     = 1'b1;
                cnt_we     = 1'b1;
                lc_waddr   = k_reg[AW-1:0];
                lab_wdata  = lab_rdata;
                cnt_wdata  = cnt_rdata;
                k_next     = k_dec;
                state_next = cln_pkg::ST_SHIFT_RD;
            end
            // Rank of each sample: position of its value in the label RAM
            cln_pkg::ST_RK_RD: begin
                state_next = cln_pkg::ST_RK_VAL;
            end
            cln_pkg::ST_RK_VAL: begin
                val_next   = smp_rdata;
                pos_next   = '0;
                state_next = cln_pkg::ST_RK_SRD;
            end
            cln_pkg::ST_RK_SRD: begin
                state_next = cln_pkg::ST_RK_CMP;
            end
            cln_pkg::ST_RK_CMP: begin
                if (lab_rdata == val_reg) begin
                    rnk_we = 1'b1;
                    if (idx_end) begin
                        idx_next   = '0;
                        state_next = cln_pkg::ST_OUT_RD;
                    end else begin
                        idx_next   = idx_reg + CW'(1);
                        state_next = cln_pkg::ST_RK_RD;
                    end
                end else begin
                    pos_next   = pos_reg + CW'(1);
                    state_next = cln_pkg::ST_RK_SRD;
                end
            end
            // Emit one item per stored sample
            cln_pkg::ST_OUT_RD: begin
                lc_raddr   = idx_reg[AW-1:0];
                state_next = cln_pkg::ST_OUT_LD;
            end
            cln_pkg::ST_OUT_LD: begin
                o_class_next = rnk_rdata;
                o_valid_next = (idx_reg < total_reg);
                o_label_next = o_valid_next ? lab_rdata : '0;
                o_count_next = o_valid_next ? cnt_rdata : '0;
                o_last_next  = idx_end;
                state_next   = cln_pkg::ST_OUT_WAIT;
            end
            cln_pkg::ST_OUT_WAIT: begin
                if (m_ready) begin
                    if (o_last_reg) begin
                        fill_next  = '0;
                        drop_next  = 1'b0;
                        total_next = '0;
                        state_next = cln_pkg::ST_LOAD;
                    end else begin
                        idx_next   = idx_reg + CW'(1);
                        state_next = cln_pkg::ST_OUT_RD;
                    end
                end
            end
            default: begin
                state_next = cln_pkg::ST_LOAD;
            end
        endcase
    end

    `CLN_ASSERT_ALWAYS(a_fill_bound, aclk, aresetn, fill_reg <= CW'(MAX_SAMPLES), "fill overrun")
    `CLN_ASSERT_ALWAYS(a_total_bound, aclk, aresetn, total_reg <= fill_reg, "more classes than samples")
    `CLN_ASSERT_ALWAYS(a_one_side, aclk, aresetn, !(s_ready && m_valid), "input open while emitting")
    `CLN_ASSERT_NEXT(a_last_ends, aclk, aresetn, m_valid && m_ready && m_last_result, s_ready && fill_reg == '0 && !drop_reg, "set not closed after last item")

endmodule

/* tb/sv/categorical_label_normalizer_tb.sv */
module categorical_label_normalizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY = 64;
    localparam int LABEL_W  = cln_pkg::LABEL_W;
    localparam int CLASS_W  = cln_pkg::CLASS_W;
    localparam int CNT_W    = cln_pkg::CNT_W;

    // One result of a set, as the block should present it.
    typedef struct {
        logic [CLASS_W-1:0] sample_class;
        logic [LABEL_W-1:0] class_label;
        logic [CNT_W-1:0]   class_count;
        logic               class_valid;
        logic [CNT_W-1:0]   class_total;
        logic               overflow;
        logic               last_result;
    } label_result_t;

    // Scoreboard: keeps its own copy of the sample store and works out the
    // label encoding of a set when the last item of it is accepted.
    class label_encoding_board;
        logic [LABEL_W-1:0] held_values[$];
        bit                 dropped;
        label_result_t      pending[$];
        int                 errors;
        int                 results_seen;
        int                 sets_closed;

        function void note_sample(logic [31:0] value, logic missing, logic last);
            logic [LABEL_W-1:0] sorted_labels[$];
            int                 label_counts[$];
            logic [LABEL_W-1:0] v;
            int                 pos;
            label_result_t      r;
            v = missing ? 32'hFFFF_FFFF : value;
            if (held_values.size() < CAPACITY) held_values.insert(held_values.size(), v);
            else dropped = 1;
            if (!last) return;
            // sorted insertion of distinct values, signed order
            foreach (held_values[i]) begin
                pos = 0;
                while (pos < sorted_labels.size() &&
                       $signed(sorted_labels[pos]) < $signed(held_values[i])) pos++;
                if (pos < sorted_labels.size() && sorted_labels[pos] == held_values[i]) begin
                    label_counts[pos]++;
                end else begin
                    sorted_labels.insert(pos, held_values[i]);
                    label_counts.insert(pos, 1);
                end
            end
            foreach (held_values[i]) begin
                pos = 0;
                while (sorted_labels[pos] != held_values[i]) pos++;
                r.sample_class = pos[CLASS_W-1:0];
                r.class_valid  = i < sorted_labels.size();
                r.class_label  = r.class_valid ? sorted_labels[i] : '0;
                r.class_count  = r.class_valid ? label_counts[i][CNT_W-1:0] : '0;
                r.class_total  = CNT_W'(sorted_labels.size());
                r.overflow     = dropped;
                r.last_result  = (i == held_values.size() - 1);
                pending.insert(pending.size(), r);
            end
            held_values.delete();
            dropped = 0;
            sets_closed++;
        endfunction

        function void check_result(label_result_t got);
            label_result_t want;
            results_seen++;
            if (pending.size() == 0) begin
                $error("result with no expectation waiting");
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.sample_class !== want.sample_class) begin
                $error("sample_class: expected %0d, got %0d", want.sample_class, got.sample_class);
                errors++;
            end
            if (got.class_label !== want.class_label) begin
                $error("class_label: expected %0d, got %0d",
                       $signed(want.class_label), $signed(got.class_label));
                errors++;
            end
            if (got.class_count !== want.class_count) begin
                $error("class_count: expected %0d, got %0d", want.class_count, got.class_count);
                errors++;
            end
            if (got.class_valid !== want.class_valid) begin
                $error("class_valid: expected %0d, got %0d", want.class_valid, got.class_valid);
                errors++;
            end
            if (got.class_total !== want.class_total) begin
                $error("class_total: expected %0d, got %0d", want.class_total, got.class_total);
                errors++;
            end
            if (got.overflow !== want.overflow) begin
                $error("overflow: expected %0d, got %0d", want.overflow, got.overflow);
                errors++;
            end
            if (got.last_result !== want.last_result) begin
                $error("last_result: expected %0d, got %0d", want.last_result, got.last_result);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_sample_value;
    logic        s_is_missing;
    logic        s_last_sample;
    logic        m_valid;
    logic        m_ready;
    logic [5:0]  m_sample_class;
    logic [31:0] m_class_label;
    logic [6:0]  m_class_count;
    logic        m_class_valid;
    logic [6:0]  m_class_total;
    logic        m_overflow;
    logic        m_last_result;

    label_encoding_board board;
    bit   sink_steady;   // when set the receiver never stalls
    int   items_sent;
    int   overflow_sets;

    categorical_label_normalizer dut (.*);

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // Offer one item at the falling edge and hold it until accepted.
    // Between items of a burst valid stays high; gaps drop it first.
    task automatic send_sample(logic [31:0] value, logic missing, logic last, int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_sample_value <= value;
        s_is_missing   <= missing;
        s_last_sample  <= last;
        do @(posedge aclk); while (!s_ready);
        board.note_sample(value, missing, last);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic pause_until_drained();
        s_valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge aclk);
    endtask

    // Random value biased towards few distinct classes so counts grow.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            3: return 32'hFFFF_FFFF;
            default: return $urandom_range(0, 7) - 3;
        endcase
    endfunction

    int burst_left;

    function automatic int next_gap();
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        burst_left = $urandom_range(0, 12);
        return $urandom_range(0, 5);
    endfunction

    task automatic send_set(int n, int extra);
        for (int i = 0; i < n + extra; i++)
            send_sample(pick_value(), $urandom_range(0, 7) == 0, i == n + extra - 1,
                        next_gap());
        if (extra > 0) overflow_sets++;
    endtask

    // Receiver: own stall pattern, sampled at the rising edge.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result('{m_sample_class, m_class_label, m_class_count,
                                 m_class_valid, m_class_total, m_overflow,
                                 m_last_result});
    end

    int stall_phase;
    always @(negedge aclk) begin
        stall_phase <= stall_phase + 1;
        if (sink_steady) m_ready <= 1'b1;
        else if (stall_phase % 23 < 6) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(0, 3) != 0);
    end

    initial begin
        board          = new();
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_sample_value = '0;
        s_is_missing   = 1'b0;
        s_last_sample  = 1'b0;
        m_ready        = 1'b0;
        stall_phase    = 0;
        sink_steady    = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: extremes, missing flag overriding a value, single-sample set.
        send_sample(32'h8000_0000, 1'b0, 1'b1, 0);
        send_sample(32'h7FFF_FFFF, 1'b0, 1'b0, 0);
        send_sample(32'h8000_0000, 1'b0, 1'b0, 0);
        send_sample(32'h1234_5678, 1'b1, 1'b0, 0);
        send_sample(32'hFFFF_FFFF, 1'b0, 1'b0, 0);
        send_sample(32'h0000_0000, 1'b0, 1'b0, 0);
        send_sample(32'h5555_5555, 1'b0, 1'b0, 0);
        send_sample(32'hAAAA_AAAA, 1'b1, 1'b0, 0);
        send_sample(32'h7FFF_FFFF, 1'b0, 1'b1, 0);
        // sender holds off until the block has drained everything
        pause_until_drained();
        // all equal values
        for (int i = 0; i < 5; i++) send_sample(32'h0000_0007, 1'b0, i == 4, 0);
        sink_steady = 1;
        // full store, distinct values mixed with missing ones, then overflow
        // with last on a dropped item
        for (int i = 0; i < 66; i++)
            send_sample(32'hC000_0000 + 32'(i * 7919), i[0], i == 65, 0);
        overflow_sets++;
        pause_until_drained();
        sink_steady = 0;

        // Random sets, mostly small.
        while (items_sent < 360) begin
            case ($urandom_range(0, 9))
                0: send_set(64, $urandom_range(0, 2));
                1: send_set(1, 0);
                default: send_set($urandom_range(2, 12), 0);
            endcase
            if ($urandom_range(0, 7) == 0) pause_until_drained();
        end
        s_valid <= 1'b0;

        while (board.pending.size() != 0) @(negedge aclk);
        repeat (50) @(negedge aclk);
        $display("Sent %0d items in %0d sets (%0d with dropped items); checked %0d results.",
                 items_sent, board.sets_closed, overflow_sets, board.results_seen);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("categorical_label_normalizer_tb: PASS");
        else
            $display("categorical_label_normalizer_tb: FAIL");
        $finish;
    end

    // Watchdog: the limit leaves ample room even for full sets.
    initial begin
        #20ms;
        $display("categorical_label_normalizer_tb: FAIL");
        $finish;
    end

endmodule
